// ===== design/imu_gyro_bias_calibrator_assert.svh =====
// Assertion macros shared by the gyro bias calibrator RTL.
// No dependencies; synthesis sees only empty macro bodies.
`ifndef IMU_GYRO_BIAS_CALIBRATOR_ASSERT_SVH
`define IMU_GYRO_BIAS_CALIBRATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked while out of reset.
`define IGBC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked while out of reset.
`define IGBC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define IGBC_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define IGBC_ASSERT_NXT(lbl, ck, rstn, ante, cons)

`endif

`endif

// ===== design/imu_gbc_pkg.sv =====
// Package for the gyro bias calibrator: word types and fixed scaling constants.
// No dependencies.
package imu_gbc_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  // 64 / 65.5 in Q0.16, rounded.
  localparam int unsigned RATE_MUL   = 64035;
  localparam int unsigned RATE_SHIFT = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x_g;
    logic signed [SAMPLE_W-1:0] accel_y_g;
    logic signed [SAMPLE_W-1:0] accel_z_g;
    logic signed [SAMPLE_W-1:0] rate_x_dps;
    logic signed [SAMPLE_W-1:0] rate_y_dps;
    logic signed [SAMPLE_W-1:0] rate_z_dps;
    logic                       rate_valid;
  } out_word_t;

endpackage

// ===== design/imu_gyro_bias_calibrator.sv =====
// Top level of the IMU gyro bias calibrator.
// Depends on imu_gbc_pkg, imu_gbc_axis and imu_gyro_bias_calibrator_assert.svh.
//
//   channel | ports                           | word
//   --------+---------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data     | in_word_t: 3 accel, 3 gyro
//   output  | out_valid, out_stall, out_data  | out_word_t: 3 g, 3 dps, flag
//
// Throughput is one word per clock while out_stall is low. A word accepted into the
// input register is corrected and scaled into the result register once that register
// can take it; out_valid rises as the result register is loaded, and the word
// leaves once out_stall is low. Reset (synchronous, rst_n low) empties both stages
// and restarts calibration. A stalled result holds in the result register while the
// input register still takes one more word, so in_stall rises only when both stages
// are full and out_stall is high.
module imu_gyro_bias_calibrator
  import imu_gbc_pkg::*;
#(
  parameter int unsigned DISCARD_SAMPLES = 32,
  parameter int unsigned AVERAGE_LOG2    = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

`include "imu_gyro_bias_calibrator_assert.svh"

  // The count runs through the discard and averaging windows and then parks
  // at CAL_END, where every further word is corrected.
  localparam int unsigned CAL_END = DISCARD_SAMPLES + (1 << AVERAGE_LOG2);
  localparam int unsigned CNT_W   = $clog2(CAL_END + 1);
  localparam int unsigned SUM_W   = SAMPLE_W + AVERAGE_LOG2;
  localparam logic [CNT_W-1:0] CNT_DISC = CNT_W'(DISCARD_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CAL_END);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;

  logic      s1_vld_r;
  in_word_t  s1_data_r;
  logic      s1_cor_r;
  logic      out_vld_r;
  out_word_t out_data_r;

  logic      in_acc;
  logic      s1_adv;
  logic      cor_now;
  out_word_t res;

  // The result register moves when it is empty or its word is being taken;
  // the input register moves whenever the result register can take its word.
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Calibration state is updated as each word is accepted, so the sums are
  // final by the time the first corrected word reaches the correction stage.
  always_comb begin
    cnt_nxt   = cnt_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    cor_now   = 1'b0;
    priority if (cnt_r < CNT_DISC) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cnt_r < CNT_END) begin
      cnt_nxt   = cnt_r + 1'b1;
      sum_x_nxt = sum_x_r + SUM_W'(in_data.gyro_x);
      sum_y_nxt = sum_y_r + SUM_W'(in_data.gyro_y);
      sum_z_nxt = sum_z_r + SUM_W'(in_data.gyro_z);
    end else begin
      cor_now = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
    end else if (in_acc) begin
      cnt_r   <= cnt_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
      s1_cor_r  <= cor_now;
    end
  end

  // Correction per axis; the acceleration words pass straight through.
  imu_gbc_axis #(.AVERAGE_LOG2(AVERAGE_LOG2)) u_axis_x (
    .en(s1_cor_r), .raw(s1_data_r.gyro_x), .sum(sum_x_r), .rate(res.rate_x_dps)
  );
  imu_gbc_axis #(.AVERAGE_LOG2(AVERAGE_LOG2)) u_axis_y (
    .en(s1_cor_r), .raw(s1_data_r.gyro_y), .sum(sum_y_r), .rate(res.rate_y_dps)
  );
  imu_gbc_axis #(.AVERAGE_LOG2(AVERAGE_LOG2)) u_axis_z (
    .en(s1_cor_r), .raw(s1_data_r.gyro_z), .sum(sum_z_r), .rate(res.rate_z_dps)
  );

  assign res.accel_x_g  = s1_data_r.accel_x;
  assign res.accel_y_g  = s1_data_r.accel_y;
  assign res.accel_z_g  = s1_data_r.accel_z;
  assign res.rate_valid = s1_cor_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A corrected word can only come out once calibration has finished.
  `IGBC_ASSERT_IMP(a_valid_after_cal, clk, rst_n,
                   out_vld_r && out_data_r.rate_valid, cnt_r == CNT_END)
  // The sample count parks at the end of calibration and never passes it.
  `IGBC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_END)
  // Once calibration is done the bias sums are frozen.
  `IGBC_ASSERT_NXT(a_sum_frozen, clk, rst_n, cnt_r == CNT_END,
                   $stable(sum_x_r) && $stable(sum_y_r) && $stable(sum_z_r))
  // The input side only stalls when both the input and the result register hold a word.
  `IGBC_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, s1_vld_r && out_vld_r)

endmodule

// ===== design/imu_gbc_axis.sv =====
// One gyro axis: bias removal, saturation and scaling to dps times 64.
// Depends on imu_gbc_pkg.
module imu_gbc_axis
  import imu_gbc_pkg::*;
#(
  parameter int unsigned AVERAGE_LOG2 = 5
) (
  input  logic                                  en,
  input  logic signed [SAMPLE_W-1:0]            raw,
  input  logic signed [SAMPLE_W+AVERAGE_LOG2-1:0] sum,
  output logic signed [SAMPLE_W-1:0]            rate
);

  localparam int unsigned SUM_W  = SAMPLE_W + AVERAGE_LOG2;
  localparam int unsigned NUM_W  = SUM_W + 1;
  localparam int unsigned MUL_W  = SAMPLE_W + 17;
  localparam logic signed [NUM_W-1:0] RND_DN = NUM_W'((1 << AVERAGE_LOG2) - 1);
  localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [NUM_W-1:0] SAT_LO = -(NUM_W'(1 << (SAMPLE_W - 1)));
  localparam logic signed [16:0]      MUL_K  = 17'(RATE_MUL);
  localparam logic signed [MUL_W-1:0] HALF   = MUL_W'(1 << (RATE_SHIFT - 1));

  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    num_adj;
  logic signed [NUM_W-1:0]    quo;
  logic signed [SAMPLE_W-1:0] quo_sat;
  logic signed [MUL_W-1:0]    prod;

  always_comb begin
    // Difference of the sample, scaled by the window length, and the sum.
    num     = (NUM_W'(raw) <<< AVERAGE_LOG2) - NUM_W'(sum);
    // Dividing by the window truncates toward zero: bias negatives up first.
    num_adj = num + (num[NUM_W-1] ? RND_DN : '0);
    quo     = num_adj >>> AVERAGE_LOG2;
    if (quo > SAT_HI) begin
      quo_sat = SAT_HI[SAMPLE_W-1:0];
    end else if (quo < SAT_LO) begin
      quo_sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      quo_sat = quo[SAMPLE_W-1:0];
    end
    // Round half up, then an arithmetic shift is the floor in both signs.
    prod = (MUL_W'(quo_sat) * MUL_W'(MUL_K)) + HALF;
    rate = en ? prod[RATE_SHIFT+SAMPLE_W-1:RATE_SHIFT] : '0;
  end

endmodule

// ===== sim/tb_imu_gyro_bias_calibrator.sv =====
// Self-checking testbench for imu_gyro_bias_calibrator: calibration phases, saturation,
// rounding and long random streams with and without random idling on both channels.
// Depends on imu_gbc_pkg and the calibrator RTL.
`timescale 1ns / 100ps

module tb_imu_gyro_bias_calibrator;
  import imu_gbc_pkg::*;

  // The block is built with its default calibration window, and the
  // predictor below uses the same numbers.
  localparam int unsigned DISCARD_SAMPLES = 32;
  localparam int unsigned AVERAGE_LOG2    = 5;
  localparam int unsigned CAL_END         = DISCARD_SAMPLES + (1 << AVERAGE_LOG2);
  localparam longint      AVG_N           = longint'(1) << AVERAGE_LOG2;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet span is one long stall or gap.
  localparam int WATCHDOG_LIMIT = 2000;
  // Pipeline depth is two registers; a few extra cycles catch stray words.
  localparam int DRAIN_CYCLES   = 6;
  localparam int MAX_PRINTS     = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  imu_gyro_bias_calibrator #(
    .DISCARD_SAMPLES(DISCARD_SAMPLES),
    .AVERAGE_LOG2   (AVERAGE_LOG2)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 12 ns period. Stimulus moves on the falling edge and every handshake is
  // judged on the rising edge, so the two never meet in one time step.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: its own sample counter and per-axis bias sums.
  int unsigned       seen_cnt;
  logic signed [20:0] sum_x, sum_y, sum_z;

  // Calibrated readings that the block still owes us, oldest first.
  out_word_t calibrated_q[$];

  int  errors;
  int  items_sent;
  int  results_checked;
  int  rates_checked;
  int  quiet_cycles;
  int  stall_left;
  bit  idle_on;

  // Mismatches all funnel through here; the printout is capped so that a
  // broken build cannot flood the log, but every one is counted.
  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_checked, name, $signed(got), $signed(want)));
  endtask

  // Bias correction and rate scaling for one axis. The division is signed,
  // so it truncates toward zero; the arithmetic shift afterwards floors, which
  // with the added half gives round half up.
  function automatic logic signed [15:0] correct_rate(input logic signed [15:0] raw,
                                                      input logic signed [20:0] sum);
    longint num;
    longint q;
    longint p;
    longint r;
    num = longint'(raw) * AVG_N - longint'(sum);
    q   = num / AVG_N;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    p = q * longint'(RATE_MUL) + (longint'(1) << (RATE_SHIFT - 1));
    r = p >>> RATE_SHIFT;
    return r[15:0];
  endfunction

  // Advances the predictor by one accepted reading and returns the word the
  // block must produce for it. Acceleration always passes straight through.
  function automatic out_word_t calibrate_reading(input in_word_t w);
    out_word_t r;
    r = '0;
    r.accel_x_g = w.accel_x;
    r.accel_y_g = w.accel_y;
    r.accel_z_g = w.accel_z;
    if (seen_cnt < DISCARD_SAMPLES) begin
      seen_cnt++;
    end else if (seen_cnt < CAL_END) begin
      sum_x += w.gyro_x;
      sum_y += w.gyro_y;
      sum_z += w.gyro_z;
      seen_cnt++;
    end else begin
      // The counter stays here for good, so the sums are frozen from now on.
      r.rate_x_dps = correct_rate(w.gyro_x, sum_x);
      r.rate_y_dps = correct_rate(w.gyro_y, sum_y);
      r.rate_z_dps = correct_rate(w.gyro_z, sum_z);
      r.rate_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(input int v);
    int c;
    c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    return c[15:0];
  endfunction

  function automatic int bias_mean(input logic signed [20:0] sum);
    return int'(sum >>> AVERAGE_LOG2);
  endfunction

  function automatic in_word_t reading(input int ax, input int ay, input int az,
                                       input int gx, input int gy, input int gz);
    in_word_t w;
    w.accel_x = clamp16(ax);
    w.accel_y = clamp16(ay);
    w.accel_z = clamp16(az);
    w.gyro_x  = clamp16(gx);
    w.gyro_y  = clamp16(gy);
    w.gyro_z  = clamp16(gz);
    return w;
  endfunction

  // Mostly uniform samples, with the end points and the values around zero
  // showing up often enough to matter.
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A gyro sample within a few hundred counts of the learned bias, so that
  // the corrected rate crosses zero and small values get rounded.
  function automatic logic signed [15:0] near_bias(input logic signed [20:0] sum);
    return clamp16(bias_mean(sum) + int'($urandom_range(0, 600)) - 300);
  endfunction

  function automatic in_word_t rand_reading();
    in_word_t w;
    w.accel_x = rand_sample();
    w.accel_y = rand_sample();
    w.accel_z = rand_sample();
    w.gyro_x  = ($urandom_range(0, 3) == 0) ? near_bias(sum_x) : rand_sample();
    w.gyro_y  = ($urandom_range(0, 3) == 0) ? near_bias(sum_y) : rand_sample();
    w.gyro_z  = ($urandom_range(0, 3) == 0) ? near_bias(sum_z) : rand_sample();
    return w;
  endfunction

  // Idle lengths: usually from the short range, now and then from the long one.
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Sends one reading, optionally after a random gap, and waits until the
  // word is accepted. The prediction is taken at the accepting edge.
  task automatic send_reading(input in_word_t w);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calibrated_q.push_back(calibrate_reading(w));
    items_sent++;
  endtask

  // Holds the input channel idle until every owed result has come out.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (calibrated_q.size() != 0) @(posedge clk);
  endtask

  // Discard window: extreme and patterned words first, then random ones.
  // Averaging window: the X bias is pulled far negative and the Y bias far
  // positive so both saturation directions are reachable afterwards; Z gets
  // a mixed-sign sum so that truncation toward zero is exercised.
  task automatic test_calibration_window();
    in_word_t w;
    send_reading(reading(-32768, -32768, -32768, -32768, -32768, -32768));
    send_reading(reading(32767, 32767, 32767, 32767, 32767, 32767));
    send_reading(reading(0, 0, 0, 0, 0, 0));
    send_reading(reading(-1, -1, -1, -1, -1, -1));
    send_reading(reading(16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555,
                         16'sh5555));
    send_reading(reading(-21846, -21846, -21846, -21846, -21846, -21846));
    for (int i = 6; i < DISCARD_SAMPLES; i++) send_reading(rand_reading());
    send_reading(reading(rand_sample(), rand_sample(), rand_sample(), -32768, 32767, 1));
    for (int i = 1; i < (1 << AVERAGE_LOG2); i++) begin
      w = rand_reading();
      w.gyro_x = clamp16(int'($urandom_range(0, 16384)) - 32768);
      w.gyro_y = clamp16(16384 + int'($urandom_range(0, 16383)));
      w.gyro_z = rand_sample();
      send_reading(w);
    end
  endtask

  // The very first reading after the averaging window must already carry a
  // corrected rate; feeding the bias itself should give a rate near zero.
  task automatic test_first_corrected_sample();
    send_reading(reading(100, -100, 8192, bias_mean(sum_x), bias_mean(sum_y),
                         bias_mean(sum_z)));
  endtask

  // Full-scale gyro words in both directions, which with the chosen biases
  // drive the correction into positive and negative saturation.
  task automatic test_extremes();
    send_reading(reading(32767, 32767, 32767, 32767, 32767, 32767));
    send_reading(reading(-32768, -32768, -32768, -32768, -32768, -32768));
    send_reading(reading(0, 0, 0, 32767, -32768, 0));
    send_reading(reading(1, -1, 0, -32768, 32767, 32767));
    send_reading(reading(-1, 1, -32768, 0, 0, -32768));
    send_reading(reading(0, 0, 0, 0, 0, 0));
    send_reading(reading(-1, -1, -1, -1, -1, -1));
    send_reading(reading(16'sh5555, -21846, 16'sh5555, -21846, 16'sh5555, -21846));
  endtask

  // Corrected values of a few counts either side of zero, where the rounding
  // of the rate multiply and the truncation of the mean are most visible.
  task automatic test_rounding_near_bias();
    for (int k = -4; k <= 4; k++)
      send_reading(reading(k, -k, k * 1000, bias_mean(sum_x) + k, bias_mean(sum_y) - k,
                           bias_mean(sum_z) + k));
  endtask

  // The sender goes quiet until the output side has caught up completely,
  // then picks up again from an empty pipeline.
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_reading(rand_reading());
    wait_for_results();
    for (int i = 0; i < 10; i++) send_reading(rand_reading());
  endtask

  task automatic test_random_stream(input int count, input bit with_idling);
    idle_on = with_idling;
    for (int i = 0; i < count; i++) send_reading(rand_reading());
    idle_on = 1'b1;
  endtask

  // Long after calibration the sums must not have moved: the same bias word
  // as right after calibration has to give the same result again.
  task automatic test_frozen_bias();
    send_reading(reading(100, -100, 8192, bias_mean(sum_x), bias_mean(sum_y),
                         bias_mean(sum_z)));
    send_reading(reading(0, 0, 0, 32767, -32768, 32767));
  endtask

  // Output side back-pressure. A stall burst is started at random and then
  // held for its whole length; with idling off no new burst is started.
  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (calibrated_q.size() == 0) begin
        report_mismatch($sformatf("result word with no reading pending: %h", out_data));
      end else begin
        want = calibrated_q.pop_front();
        compare_field("accel_x_g", out_data.accel_x_g, want.accel_x_g);
        compare_field("accel_y_g", out_data.accel_y_g, want.accel_y_g);
        compare_field("accel_z_g", out_data.accel_z_g, want.accel_z_g);
        compare_field("rate_x_dps", out_data.rate_x_dps, want.rate_x_dps);
        compare_field("rate_y_dps", out_data.rate_y_dps, want.rate_y_dps);
        compare_field("rate_z_dps", out_data.rate_z_dps, want.rate_z_dps);
        compare_field("rate_valid", {15'd0, out_data.rate_valid}, {15'd0, want.rate_valid});
        if (want.rate_valid) rates_checked++;
        results_checked++;
      end
    end
  end

  // Watchdog: any accepted word on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, quiet_cycles);
      $display("imu_gyro_bias_calibrator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    seen_cnt        = 0;
    sum_x           = '0;
    sum_y           = '0;
    sum_z           = '0;
    errors          = 0;
    items_sent      = 0;
    results_checked = 0;
    rates_checked   = 0;
    quiet_cycles    = 0;
    stall_left      = 0;
    idle_on         = 1'b1;

    // Synchronous reset, held low from the start and released once.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_calibration_window();
    test_first_corrected_sample();
    test_extremes();
    test_rounding_near_bias();
    test_drain_pause();
    test_random_stream(400, 1'b1);
    test_random_stream(150, 1'b0);
    test_random_stream(250, 1'b1);
    test_frozen_bias();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (calibrated_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", calibrated_q.size()));

    $display("Sent %0d readings through discard, averaging and corrected phases,",
             items_sent);
    $display("checked %0d result words, %0d of them with calibrated rates.",
             results_checked, rates_checked);
    if (errors == 0) begin
      $display("imu_gyro_bias_calibrator test passed");
    end else begin
      $display("imu_gyro_bias_calibrator test failed");
    end
    $finish;
  end

endmodule
